// File: rtl/seq_pkg.sv
`default_nettype none

package seq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH     = 16;
   localparam int SECTOR_WIDTH    = 32;
   localparam int REQUESTER_WIDTH = 8;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int STATUS_W = 2;

   // Stream payload widths, rounded up to whole bytes
   localparam int REQ_FIELDS_W = SECTOR_WIDTH + REQUESTER_WIDTH;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + REQUESTER_WIDTH + SECTOR_WIDTH + STATUS_W + CNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Bit positions of the result fields inside rsp_tdata
   localparam int RSP_REQ_LSB    = 1;
   localparam int RSP_SEC_LSB    = RSP_REQ_LSB + REQUESTER_WIDTH;
   localparam int RSP_STATUS_LSB = RSP_SEC_LSB + SECTOR_WIDTH;
   localparam int RSP_COUNT_LSB  = RSP_STATUS_LSB + STATUS_W;

   // Item kind carried on req_tuser
   localparam logic KIND_SUBMIT   = 1'b0;
   localparam logic KIND_COMPLETE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COMMIT
   } state_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic load;    // capture the input transfer
      logic eval;    // compare keys, work out neighbor and direction
      logic commit;  // update queue and load the result register
   } dp_cmd_type;

endpackage

`default_nettype wire

// File: rtl/seq_ctrl.sv
`default_nettype none

module seq_ctrl
   import seq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output dp_cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/seq_datapath.sv
`default_nettype none

module seq_datapath
   import seq_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dp_cmd_type                 cmd,
   input  wire logic                       in_kind,
   input  wire logic [SECTOR_WIDTH-1:0]    in_sector,
   input  wire logic [REQUESTER_WIDTH-1:0] in_requester,
   output logic                            out_grant,
   output logic [REQUESTER_WIDTH-1:0]      out_requester,
   output logic [SECTOR_WIDTH-1:0]         out_sector,
   output logic [STATUS_W-1:0]             out_status,
   output logic [CNT_W-1:0]                out_count
);

   // Sorted register array, ascending sector key
   logic [SECTOR_WIDTH-1:0]    sec_ff [QUEUE_DEPTH];
   logic [SECTOR_WIDTH-1:0]    sec_in [QUEUE_DEPTH];
   logic [REQUESTER_WIDTH-1:0] rid_ff [QUEUE_DEPTH];
   logic [REQUESTER_WIDTH-1:0] rid_in [QUEUE_DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] serve_ff, serve_in;
   logic             down_ff, down_in;

   // Captured input transfer
   logic                       kind_ff;
   logic [SECTOR_WIDTH-1:0]    key_ff;
   logic [REQUESTER_WIDTH-1:0] who_ff;

   // Evaluation results
   logic [QUEUE_DEPTH-1:0] gt_ff, gt_in;
   logic [IDX_W-1:0]       p_ff, p_in;
   logic [IDX_W-1:0]       next_ff, next_in;
   logic                   have_next_ff, have_next_in;
   logic                   down_nx_ff, down_nx_in;
   logic                   full_ff, empty_ff;

   // Result register
   logic                       grant_ff, grant_in;
   logic [REQUESTER_WIDTH-1:0] orid_ff, orid_in;
   logic [SECTOR_WIDTH-1:0]    osec_ff, osec_in;
   status_type                 status_ff, status_in;
   logic [CNT_W-1:0]           ocount_ff;

   logic [CNT_W-1:0] p_plus1;

   // gt[i]: entry i is empty or holds a larger key, so it moves up on insert
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         gt_in[i] = !((CNT_W'(i) < count_ff) && (sec_ff[i] <= key_ff));
      end
   end

   always_comb begin
      p_in = (CNT_W'(serve_ff) >= count_ff) ? IDX_W'(count_ff - CNT_W'(1)) : serve_ff;
      p_plus1 = CNT_W'(p_in) + CNT_W'(1);
      if (!down_ff) down_nx_in = (p_plus1 >= count_ff);
      else          down_nx_in = (p_in != '0);
      // direction only turns back up at the bottom
      if (down_ff && p_in == '0) down_nx_in = 1'b0;
      else if (down_ff)          down_nx_in = 1'b1;
      if (down_nx_in) begin
         have_next_in = (p_in != '0);
         next_in      = p_in - IDX_W'(1);
      end else begin
         have_next_in = (p_plus1 < count_ff);
         next_in      = p_in + IDX_W'(1);
      end
   end

   // Queue update on commit
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sec_in[i] = sec_ff[i];
         rid_in[i] = rid_ff[i];
      end
      count_in  = count_ff;
      serve_in  = serve_ff;
      down_in   = down_ff;
      grant_in  = 1'b0;
      orid_in   = '0;
      osec_in   = '0;
      status_in = STATUS_OK;
      if (kind_ff == KIND_SUBMIT) begin
         if (full_ff) begin
            status_in = STATUS_FULL;
         end else begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (gt_ff[i]) begin
                  if (i > 0 && gt_ff[(i > 0) ? i - 1 : 0]) begin
                     sec_in[i] = sec_ff[(i > 0) ? i - 1 : 0];
                     rid_in[i] = rid_ff[(i > 0) ? i - 1 : 0];
                  end else begin
                     sec_in[i] = key_ff;
                     rid_in[i] = who_ff;
                  end
               end
            end
            count_in = count_ff + CNT_W'(1);
            if (empty_ff) begin
               serve_in = '0;
               grant_in = 1'b1;
               orid_in  = who_ff;
               osec_in  = key_ff;
            end else if (gt_ff[serve_ff]) begin
               serve_in = serve_ff + IDX_W'(1);
            end
         end
      end else begin
         if (empty_ff) begin
            status_in = STATUS_EMPTY;
         end else begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
               if (IDX_W'(i) >= p_ff) begin
                  sec_in[i] = sec_ff[i + 1];
                  rid_in[i] = rid_ff[i + 1];
               end
            end
            count_in = count_ff - CNT_W'(1);
            down_in  = down_nx_ff;
            if (have_next_ff) begin
               serve_in = down_nx_ff ? (p_ff - IDX_W'(1)) : p_ff;
               grant_in = 1'b1;
               orid_in  = rid_ff[next_ff];
               osec_in  = sec_ff[next_ff];
            end else begin
               serve_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         serve_ff <= '0;
         down_ff  <= 1'b0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         serve_ff <= serve_in;
         down_ff  <= down_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            sec_ff[i] <= sec_in[i];
            rid_ff[i] <= rid_in[i];
         end
         grant_ff  <= grant_in;
         orid_ff   <= orid_in;
         osec_ff   <= osec_in;
         status_ff <= status_in;
         ocount_ff <= count_in;
      end
      if (cmd.load) begin
         kind_ff <= in_kind;
         key_ff  <= in_sector;
         who_ff  <= in_requester;
      end
      if (cmd.eval) begin
         gt_ff        <= gt_in;
         p_ff         <= p_in;
         next_ff      <= next_in;
         have_next_ff <= have_next_in;
         down_nx_ff   <= down_nx_in;
         full_ff      <= (count_ff >= CNT_W'(QUEUE_DEPTH));
         empty_ff     <= (count_ff == '0);
      end
   end

   assign out_grant     = grant_ff;
   assign out_requester = orid_ff;
   assign out_sector    = osec_ff;
   assign out_status    = status_ff;
   assign out_count     = ocount_ff;

endmodule

`default_nettype wire

// File: rtl/scan_elevator_request_queue_core.sv
// Channel  Dir  Signals                         Payload
// req      in   req_tvalid/tready/tdata/tuser   tdata: sector_index, requester_id; tuser: kind
// rsp      out  rsp_tvalid/tready/tdata         tdata: grant_valid, granted_requester,
//                                               granted_sector, status, queue_count
//
// An item runs through the input transfer, a step of key compares and
// neighbor/direction selection, and a step that shifts the register array and
// loads the result register. The next input is taken the cycle after that.
// A stalled rsp holds the result; the next item runs to its commit step and waits there.
// Synchronous active-high reset empties the queue and points the sweep upward.
`default_nettype none

module scan_elevator_request_queue_core
   import seq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sector_index [SECTOR_WIDTH-1:0], requester_id above it, zero padded
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  wire logic                  req_tuser,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // grant_valid, granted_requester, granted_sector, status, queue_count, zero padded
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready
);

   dp_cmd_type cmd;

   logic                       grant;
   logic [REQUESTER_WIDTH-1:0] grant_rid;
   logic [SECTOR_WIDTH-1:0]    grant_sec;
   logic [STATUS_W-1:0]        status;
   logic [CNT_W-1:0]           count;

   // Handshake sequencing: idle -> evaluate -> commit
   seq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Sorted queue, sweep pointer and result register
   seq_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .in_kind       (req_tuser),
      .in_sector     (req_tdata[SECTOR_WIDTH-1:0]),
      .in_requester  (req_tdata[REQ_FIELDS_W-1:SECTOR_WIDTH]),
      .out_grant     (grant),
      .out_requester (grant_rid),
      .out_sector    (grant_sec),
      .out_status    (status),
      .out_count     (count)
   );

   assign rsp_tdata = RSP_DATA_W'({count, status, grant_sec, grant_rid, grant});

endmodule

`default_nettype wire

// File: rtl/seq_checker.sv
`default_nettype none

module seq_checker
   import seq_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready
);

   logic                        grant;
   logic [STATUS_W-1:0]         status;
   logic [CNT_W-1:0]            count;
   logic [RSP_STATUS_LSB-2:0]   grant_fields;

   assign grant        = rsp_tdata[0];
   assign grant_fields = rsp_tdata[RSP_STATUS_LSB-1:RSP_REQ_LSB];
   assign status       = rsp_tdata[RSP_COUNT_LSB-1:RSP_STATUS_LSB];
   assign count        = rsp_tdata[RSP_COUNT_LSB+CNT_W-1:RSP_COUNT_LSB];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !grant |-> grant_fields == '0)
      else $error("grant fields not zero without grant");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == STATUS_FULL |-> !grant && count == CNT_W'(QUEUE_DEPTH))
      else $error("full reject with grant or short queue");

   a_empty_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == STATUS_EMPTY |-> !grant && count == '0)
      else $error("empty complete with grant or entries");

endmodule

bind scan_elevator_request_queue_core seq_checker u_seq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

// File: tb/sv/seq_grant_checker.sv
module seq_grant_checker
   import seq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output int                         mismatches,
   output int                         pending_results,
   output int                         checked_results,
   output int                         grants_seen,
   output int                         full_rejects,
   output int                         empty_completes
);

   typedef struct packed {
      logic                       grant;
      logic [REQUESTER_WIDTH-1:0] owner;
      logic [SECTOR_WIDTH-1:0]    sector;
      logic [STATUS_W-1:0]        status;
      logic [CNT_W-1:0]           count;
   } grant_rec_type;

   // shadow copy of the queue
   logic [SECTOR_WIDTH-1:0]    key_q   [QUEUE_DEPTH];
   logic [REQUESTER_WIDTH-1:0] owner_q [QUEUE_DEPTH];
   int                         held       = 0;
   int                         serve_at   = 0;
   bit                         sweep_down = 1'b0;

   grant_rec_type due_grants[$];

   initial begin
      mismatches      = 0;
      pending_results = 0;
      checked_results = 0;
      grants_seen     = 0;
      full_rejects    = 0;
      empty_completes = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= 60)
         $display("[%0t] result %0d: %s got 0x%0h want 0x%0h",
                  $realtime, checked_results, what, got, want);
   endtask

   // One SCAN scheduler step; updates the shadow queue.
   function automatic grant_rec_type elevator_step(input logic kind,
                                                   input logic [SECTOR_WIDTH-1:0] sec,
                                                   input logic [REQUESTER_WIDTH-1:0] owner);
      grant_rec_type r;
      int            slot;
      int            i;
      int            p;
      int            nxt;
      bit            has_next;
      r        = '0;
      r.status = STATUS_OK;
      if (kind == KIND_SUBMIT) begin
         if (held >= QUEUE_DEPTH) begin
            r.status = STATUS_FULL;
            r.count  = CNT_W'(held);
            return r;
         end
         slot = 0;
         while (slot < held && key_q[slot] <= sec)
            slot++;
         for (i = held; i > slot; i--) begin
            key_q[i]   = key_q[i-1];
            owner_q[i] = owner_q[i-1];
         end
         key_q[slot]   = sec;
         owner_q[slot] = owner;
         held++;
         if (held == 1) begin
            serve_at = 0;
            r.grant  = 1'b1;
            r.owner  = owner;
            r.sector = sec;
         end else if (serve_at >= slot) begin
            serve_at++;
         end
      end else begin
         if (held == 0) begin
            r.status = STATUS_EMPTY;
            return r;
         end
         p = (serve_at >= held) ? held - 1 : serve_at;
         if (!sweep_down) begin
            if (p + 1 >= held)
               sweep_down = 1'b1;
         end else if (p == 0) begin
            sweep_down = 1'b0;
         end
         if (!sweep_down) begin
            has_next = (p + 1 < held);
            nxt      = p + 1;
         end else begin
            has_next = (p > 0);
            nxt      = p - 1;
         end
         if (has_next) begin
            r.grant  = 1'b1;
            r.owner  = owner_q[nxt];
            r.sector = key_q[nxt];
         end
         for (i = p; i + 1 < held; i++) begin
            key_q[i]   = key_q[i+1];
            owner_q[i] = owner_q[i+1];
         end
         held--;
         serve_at = has_next ? (sweep_down ? p - 1 : p) : 0;
      end
      r.count = CNT_W'(held);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      grant_rec_type want;
      grant_rec_type got;
      if (reset) begin
         held       = 0;
         serve_at   = 0;
         sweep_down = 1'b0;
         due_grants.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.grant  = rsp_tdata[0];
            got.owner  = rsp_tdata[RSP_REQ_LSB +: REQUESTER_WIDTH];
            got.sector = rsp_tdata[RSP_SEC_LSB +: SECTOR_WIDTH];
            got.status = rsp_tdata[RSP_STATUS_LSB +: STATUS_W];
            got.count  = rsp_tdata[RSP_COUNT_LSB +: CNT_W];
            if (due_grants.size() == 0) begin
               report_mismatch("transfer with nothing pending", 64'(rsp_tdata), '0);
            end else begin
               want = due_grants.pop_front();
               if (got.grant !== want.grant)
                  report_mismatch("grant_valid", 64'(got.grant), 64'(want.grant));
               if (got.owner !== want.owner)
                  report_mismatch("granted_requester", 64'(got.owner), 64'(want.owner));
               if (got.sector !== want.sector)
                  report_mismatch("granted_sector", 64'(got.sector), 64'(want.sector));
               if (got.status !== want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.count !== want.count)
                  report_mismatch("queue_count", 64'(got.count), 64'(want.count));
               checked_results++;
               if (want.grant)
                  grants_seen++;
               if (want.status == STATUS_FULL)
                  full_rejects++;
               if (want.status == STATUS_EMPTY)
                  empty_completes++;
            end
         end
         if (req_tvalid && req_tready)
            due_grants.push_back(elevator_step(req_tuser,
                                               req_tdata[SECTOR_WIDTH-1:0],
                                               req_tdata[SECTOR_WIDTH +: REQUESTER_WIDTH]));
      end
      pending_results = due_grants.size();
   end

endmodule

// File: tb/sv/tb.sv
// Testbench for the SCAN request queue.
// Stimulus: a short directed run (complete on an empty queue, grant on first submit,
// inserts ahead of the served entry, equal keys, sweep flip, filling to full and a
// rejected submit), then random phases whose submit/complete mix swings the queue
// between empty and full. A checker module beside the DUT predicts every result.
module tb;
   import seq_pkg::*;

   localparam int RANDOM_ITEMS = 1850;

   typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_type;
   typedef enum {KEY_WIDE, KEY_NARROW, KEY_CLUSTER, KEY_EDGE} key_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = KIND_SUBMIT;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   int mismatches;
   int pending_results;
   int checked_results;
   int grants_seen;
   int full_rejects;
   int empty_completes;

   // sender bookkeeping
   int items_sent     = 0;
   int submits_sent   = 0;
   int completes_sent = 0;
   int burst_left     = 0;

   // receiver state
   int          next_hold_at = 300;  // items sent before the next long rsp hold-off
   int          hold_left    = 0;
   int          mode_left    = 0;
   rx_mode_type ready_mode   = RX_OPEN;
   logic [1:0]  beat         = '0;

   always #2 clock = ~clock;

   scan_elevator_request_queue_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   seq_grant_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .mismatches      (mismatches),
      .pending_results (pending_results),
      .checked_results (checked_results),
      .grants_seen     (grants_seen),
      .full_rejects    (full_rejects),
      .empty_completes (empty_completes)
   );

   // Receiver: ready pattern changes mode every so often. Twice during the random
   // part it holds off for a long stretch while the sender keeps going, so the
   // result register and the commit stage fill and req_tready drops.
   always @(posedge clock) begin
      beat <= beat + 2'd1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (items_sent >= next_hold_at) begin
         rsp_tready   <= 1'b0;
         hold_left    <= $urandom_range(120, 200);
         next_hold_at <= (next_hold_at < 1000) ? 1100 : 32'h7fff_ffff;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= rx_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            RX_OPEN:  rsp_tready <= 1'b1;
            RX_LIGHT: rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:  rsp_tready <= (beat == 2'd0);
         endcase
      end
   end

   // Bursts of back-to-back transfers, then a gap. Long bursts give stretches
   // with no idling at all.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Offer one item and wait for its transfer. Called right after a rising edge.
   task automatic send_item(input logic kind, input logic [SECTOR_WIDTH-1:0] sec,
                            input logic [REQUESTER_WIDTH-1:0] owner);
      req_tdata  <= REQ_DATA_W'({owner, sec});
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (kind == KIND_SUBMIT)
         submits_sent++;
      else
         completes_sent++;
      pace_sender();
   endtask

   // Sender stops until every outstanding result has been taken.
   task automatic drain_pause();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   function automatic logic [SECTOR_WIDTH-1:0] pick_sector(input key_mode_type mode,
                                                          input logic [SECTOR_WIDTH-1:0] base);
      case (mode)
         KEY_NARROW:  return SECTOR_WIDTH'($urandom_range(0, 7));
         KEY_CLUSTER: return base + SECTOR_WIDTH'($urandom_range(0, 31));
         KEY_EDGE:    return $urandom_range(0, 1) ? '1 : '0;
         default:     return SECTOR_WIDTH'($urandom);
      endcase
   endfunction

   initial begin
      int                      n;
      int                      phase_left;
      int                      submit_pct;
      int                      random_done;
      int                      waited;
      key_mode_type            key_mode;
      logic [SECTOR_WIDTH-1:0] cluster_base;
      logic                    kind;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      send_item(KIND_COMPLETE, '1, '1);                // complete with nothing queued
      send_item(KIND_SUBMIT, '1, '1);                  // empty queue: granted at once
      send_item(KIND_SUBMIT, '0, '0);                  // goes in ahead of the served entry
      send_item(KIND_SUBMIT, 32'h8000_0000, 8'hA5);
      send_item(KIND_SUBMIT, 32'h8000_0000, 8'h5A);    // equal key lands behind
      send_item(KIND_COMPLETE, '0, '0);                // top of the sweep, turns down
      send_item(KIND_COMPLETE, '1, '1);
      for (n = 0; n < 14; n++)                         // fill to full, some duplicate keys
         send_item(KIND_SUBMIT, n[0] ? SECTOR_WIDTH'($urandom) : 32'h0000_0010,
                   REQUESTER_WIDTH'(n * 17));
      send_item(KIND_SUBMIT, 32'h0000_0020, 8'h3C);    // rejected, queue full
      repeat (3) send_item(KIND_COMPLETE, SECTOR_WIDTH'($urandom), REQUESTER_WIDTH'($urandom));
      drain_pause();

      // ---- random part ----
      // Each phase fixes a submit/complete mix and a key style, so the queue
      // drifts toward full, toward empty, or hovers in between.
      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         phase_left   = $urandom_range(10, 60);
         case ($urandom_range(0, 4))
            0:       submit_pct = 85;
            1:       submit_pct = 65;
            2:       submit_pct = 50;
            3:       submit_pct = 35;
            default: submit_pct = 15;
         endcase
         key_mode     = key_mode_type'($urandom_range(0, 3));
         cluster_base = SECTOR_WIDTH'($urandom);
         while (phase_left > 0 && random_done < RANDOM_ITEMS) begin
            kind = ($urandom_range(1, 100) <= submit_pct) ? KIND_SUBMIT : KIND_COMPLETE;
            // edge keys only now and then, mostly wide otherwise
            send_item(kind,
                      (key_mode == KEY_EDGE && $urandom_range(0, 2) != 0)
                         ? SECTOR_WIDTH'($urandom) : pick_sector(key_mode, cluster_base),
                      REQUESTER_WIDTH'($urandom));
            phase_left--;
            random_done++;
            if (random_done == 700 || random_done == 1400)
               drain_pause();
         end
      end

      // ---- wind down ----
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_results != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (pending_results != 0)
         $display("%0d results never arrived", pending_results);
      $display("%0d transfers in (%0d submits, %0d completes), %0d results compared",
               items_sent, submits_sent, completes_sent, checked_results);
      $display("%0d grants, %0d full-queue rejects, %0d completes on an empty queue",
               grants_seen, full_rejects, empty_completes);
      if (mismatches == 0 && pending_results == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #2000000;
      $display("watchdog expired with %0d results outstanding", pending_results);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: scan_elevator_request_queue_core.f
rtl/seq_pkg.sv
rtl/seq_ctrl.sv
rtl/seq_datapath.sv
rtl/scan_elevator_request_queue_core.sv
rtl/seq_checker.sv
tb/sv/seq_grant_checker.sv
tb/sv/tb.sv
